FILE: design/cab_pkg.sv
// shared constants and types for the color angle region box
package cab_pkg;

  localparam int DefFrameHeight = 260;
  localparam int DefFrameWidth  = 480;

  localparam int RefW    = 12;
  localparam int CosW    = 16;
  localparam int MarginW = 9;
  localparam int CoordW  = 9;
  localparam int ChanW   = 8;

  localparam int DotW  = 22;  // 3 * 4095 * 255
  localparam int NpixW = 18;  // 3 * 255 * 255
  localparam int NrefW = 26;  // 3 * 4095 * 4095
  localparam int DsqW  = 44;
  localparam int CnW   = CosW + NrefW;
  localparam int HalfW = CnW / 2;
  localparam int ProdW = HalfW + NpixW;
  localparam int CmpW  = DsqW + 16;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] REG_REF_RED       = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_REF_GREEN     = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_REF_BLUE      = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_COS_SQ_LIMIT  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_TOP_MARGIN    = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_BOTTOM_MARGIN = 3'd5;

  localparam logic [CosW-1:0]    COS_SQ_RESET = 16'd63557;
  localparam logic [MarginW-1:0] TOP_RESET    = 9'd10;
  localparam logic [MarginW-1:0] BOTTOM_RESET = 9'd20;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              last;
    logic              in_win;
    logic [DotW-1:0]   dot;
    logic [NpixW-1:0]  npix;
  } cab_item_t;

endpackage

FILE: design/cab_front.sv
// front end: takes pixels, checks the row window, forms dot product and pixel norm
module cab_front
  import cab_pkg::*;
#(
  parameter int FRAME_HEIGHT = DefFrameHeight,
  parameter int FRAME_WIDTH  = DefFrameWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [CoordW-1:0]  pix_row,
  input  logic [CoordW-1:0]  pix_col,
  input  logic [ChanW-1:0]   pix_red,
  input  logic [ChanW-1:0]   pix_green,
  input  logic [ChanW-1:0]   pix_blue,
  input  logic               frame_end,
  input  logic [RefW-1:0]    ref_red,
  input  logic [RefW-1:0]    ref_green,
  input  logic [RefW-1:0]    ref_blue,
  input  logic [MarginW-1:0] top_margin,
  input  logic [MarginW-1:0] bottom_margin,
  input  logic               q_full,
  output logic               q_push,
  output cab_item_t          q_item
);

  localparam int LimMax = (FRAME_HEIGHT > FRAME_WIDTH) ? FRAME_HEIGHT : FRAME_WIDTH;
  localparam int LimW   = $clog2(LimMax + 1);
  localparam int WinW   = (LimW > CoordW + 1) ? LimW : CoordW + 1;
  localparam logic [WinW-1:0] HLim = WinW'(FRAME_HEIGHT);
  localparam logic [WinW-1:0] WLim = WinW'(FRAME_WIDTH);

  logic            f_valid;
  cab_item_t       f_item;
  cab_item_t       f_next;
  logic [WinW-1:0] row_sum;
  logic            load;

  assign full   = f_valid && q_full;
  assign q_push = f_valid && !q_full;
  assign load   = push && !full;
  assign q_item = f_item;

  always_comb begin
    row_sum       = WinW'(pix_row) + WinW'(bottom_margin);
    f_next.row    = pix_row;
    f_next.col    = pix_col;
    f_next.last   = frame_end;
    f_next.in_win = (pix_row >= top_margin) && (row_sum < HLim) && (WinW'(pix_col) < WLim);
    f_next.dot    = DotW'(ref_red) * DotW'(pix_red)
                  + DotW'(ref_green) * DotW'(pix_green)
                  + DotW'(ref_blue) * DotW'(pix_blue);
    f_next.npix   = NpixW'(pix_red) * NpixW'(pix_red)
                  + NpixW'(pix_green) * NpixW'(pix_green)
                  + NpixW'(pix_blue) * NpixW'(pix_blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_item <= f_next;
    end
  end

endmodule

FILE: design/cab_queue.sv
// short queue between front and back
module cab_queue
  import cab_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cab_item_t din,
  output logic      full,
  input  logic      pop,
  output cab_item_t dout,
  output logic      empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  cab_item_t       mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == DepthCnt);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

FILE: design/cab_back.sv
// back end: angle test over split multiplies, running box, result register
module cab_back
  import cab_pkg::*;
#(
  parameter int FRAME_HEIGHT = DefFrameHeight,
  parameter int FRAME_WIDTH  = DefFrameWidth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  cab_item_t         q_item,
  output logic              q_pop,
  input  logic [CosW-1:0]   cos_sq_limit,
  input  logic [NrefW-1:0]  nref,
  input  logic              pop,
  output logic              out_valid,
  output logic              is_field,
  output logic              box_ready,
  output logic [CoordW-1:0] box_top,
  output logic [CoordW-1:0] box_bottom,
  output logic [CoordW-1:0] box_left,
  output logic [CoordW-1:0] box_right
);

  localparam int LimMax = (FRAME_HEIGHT > FRAME_WIDTH) ? FRAME_HEIGHT : FRAME_WIDTH;
  localparam int LimW   = $clog2(LimMax + 1);
  localparam int RunW   = (LimW > CoordW) ? LimW : CoordW;
  localparam logic [RunW-1:0] TopInit  = RunW'(FRAME_HEIGHT);
  localparam logic [RunW-1:0] LeftInit = RunW'(FRAME_WIDTH);

  logic adv;

  logic             s1_valid;
  cab_item_t        s1_item;
  logic [DsqW-1:0]  s1_dsq;
  logic [CnW-1:0]   s1_cn;

  logic             s2_valid;
  cab_item_t        s2_item;
  logic [DsqW-1:0]  s2_dsq;
  logic [ProdW-1:0] s2_plo;
  logic [ProdW-1:0] s2_phi;

  logic [CmpW-1:0]  lhs;
  logic [CmpW-1:0]  rhs;
  logic             hit;

  logic [RunW-1:0]  run_top, run_bottom, run_left, run_right;
  logic [RunW-1:0]  top_next, bottom_next, left_next, right_next;
  logic [RunW-1:0]  row_ext, col_ext;

  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_empty;

  // stage 1: square of dot, limit times reference norm
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= q_item;
      s1_dsq  <= DsqW'(q_item.dot) * DsqW'(q_item.dot);
      s1_cn   <= CnW'(cos_sq_limit) * CnW'(nref);
    end
  end

  // stage 2: right side split in two halves times pixel norm
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item <= s1_item;
      s2_dsq  <= s1_dsq;
      s2_plo  <= ProdW'(s1_cn[HalfW-1:0]) * ProdW'(s1_item.npix);
      s2_phi  <= ProdW'(s1_cn[CnW-1:HalfW]) * ProdW'(s1_item.npix);
    end
  end

  // stage 3: compare and box update
  always_comb begin
    lhs     = {s2_dsq, 16'b0};
    rhs     = {s2_phi, {HalfW{1'b0}}} + CmpW'(s2_plo);
    hit     = s2_item.in_win && (s2_item.dot != '0) && (lhs > rhs);
    row_ext = RunW'(s2_item.row);
    col_ext = RunW'(s2_item.col);
    top_next    = (hit && row_ext < run_top)    ? row_ext : run_top;
    bottom_next = (hit && row_ext > run_bottom) ? row_ext : run_bottom;
    left_next   = (hit && col_ext < run_left)   ? col_ext : run_left;
    right_next  = (hit && col_ext > run_right)  ? col_ext : run_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      run_top    <= TopInit;
      run_bottom <= '0;
      run_left   <= LeftInit;
      run_right  <= '0;
    end else if (adv) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        if (s2_item.last) begin
          run_top    <= TopInit;
          run_bottom <= '0;
          run_left   <= LeftInit;
          run_right  <= '0;
        end else begin
          run_top    <= top_next;
          run_bottom <= bottom_next;
          run_left   <= left_next;
          run_right  <= right_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_field  <= hit;
      box_ready <= s2_item.last;
      box_top    <= s2_item.last ? top_next[CoordW-1:0]    : '0;
      box_bottom <= s2_item.last ? bottom_next[CoordW-1:0] : '0;
      box_left   <= s2_item.last ? left_next[CoordW-1:0]   : '0;
      box_right  <= s2_item.last ? right_next[CoordW-1:0]  : '0;
    end
  end

endmodule

FILE: design/color_angle_region_box_top.sv
// top level: color angle segmentation with running bounding box
//
// pixels come in through a queue-style port: a beat is taken when push is
// high and full is low. each beat carries row, column, rgb and frame_end.
// every pixel gives exactly one result beat, in order, offered while empty
// is low and taken when pop is high. is_field flags a pixel inside the row
// window whose color lies within the angle limit of the reference color.
// on the beat with frame_end set, box_ready is high and the box fields give
// the bounding box of matched pixels including that one; otherwise they
// read zero. the box then starts over.
// an accepted pixel passes through the front register, the queue, the two
// back multiply stages and the result register; one pixel per cycle is
// sustained while pop stays high. the back end's two multiply stages and
// its compare stage advance together. a four-entry queue sits between the
// front and back ends; when pop stays low, the result register and the back
// stages hold, the queue and the front register fill up and then full goes high.
// reset clears the pipeline and box and loads the register defaults.
// the configuration port writes one register per cycle; nothing is read back.
// the user must write only while no pixel is in flight; the block does not check.
module color_angle_region_box_top
  import cab_pkg::*;
#(
  parameter int FRAME_HEIGHT = DefFrameHeight,
  parameter int FRAME_WIDTH  = DefFrameWidth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [CoordW-1:0]   pix_row,
  input  logic [CoordW-1:0]   pix_col,
  input  logic [ChanW-1:0]    pix_red,
  input  logic [ChanW-1:0]    pix_green,
  input  logic [ChanW-1:0]    pix_blue,
  input  logic                frame_end,
  output logic                empty,
  input  logic                pop,
  output logic                is_field,
  output logic                box_ready,
  output logic [CoordW-1:0]   box_top,
  output logic [CoordW-1:0]   box_bottom,
  output logic [CoordW-1:0]   box_left,
  output logic [CoordW-1:0]   box_right,
  input  logic                cfg_write,
  input  logic [CfgAddrW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [RefW-1:0]    ref_red, ref_green, ref_blue;
  logic [CosW-1:0]    cos_sq_limit;
  logic [MarginW-1:0] top_margin, bottom_margin;
  logic [NrefW-1:0]   nref;

  logic      q_push, q_full, q_pop, q_empty;
  cab_item_t q_in, q_out;
  logic      out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_red       <= '0;
      ref_green     <= '0;
      ref_blue      <= '0;
      cos_sq_limit  <= COS_SQ_RESET;
      top_margin    <= TOP_RESET;
      bottom_margin <= BOTTOM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REF_RED:       ref_red       <= cfg_data[RefW-1:0];
        REG_REF_GREEN:     ref_green     <= cfg_data[RefW-1:0];
        REG_REF_BLUE:      ref_blue      <= cfg_data[RefW-1:0];
        REG_COS_SQ_LIMIT:  cos_sq_limit  <= cfg_data[CosW-1:0];
        REG_TOP_MARGIN:    top_margin    <= cfg_data[MarginW-1:0];
        REG_BOTTOM_MARGIN: bottom_margin <= cfg_data[MarginW-1:0];
        default: ;
      endcase
    end
  end

  // reference norm is registered, following the registers in the next cycle
  always_ff @(posedge clk) begin
    nref <= NrefW'(ref_red) * NrefW'(ref_red)
          + NrefW'(ref_green) * NrefW'(ref_green)
          + NrefW'(ref_blue) * NrefW'(ref_blue);
  end

  cab_front #(
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pix_row      (pix_row),
    .pix_col      (pix_col),
    .pix_red      (pix_red),
    .pix_green    (pix_green),
    .pix_blue     (pix_blue),
    .frame_end    (frame_end),
    .ref_red      (ref_red),
    .ref_green    (ref_green),
    .ref_blue     (ref_blue),
    .top_margin   (top_margin),
    .bottom_margin(bottom_margin),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  cab_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_out),
    .empty(q_empty)
  );

  cab_back #(
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .cos_sq_limit(cos_sq_limit),
    .nref        (nref),
    .pop         (pop),
    .out_valid   (out_valid),
    .is_field    (is_field),
    .box_ready   (box_ready),
    .box_top     (box_top),
    .box_bottom  (box_bottom),
    .box_left    (box_left),
    .box_right   (box_right)
  );

  assign empty = !out_valid;

endmodule
